FILE: src/rwr_pkg.sv
// ----------------------------------------------------------------------------
// rwr_pkg: shared types and constants of the reordering window receiver
// Sequence space, payload layout, result kinds, register indexes and the
// command and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rwr_pkg;

	localparam int SEQ_SPACE     = 12;
	localparam int SEQ_W         = $clog2(SEQ_SPACE);
	localparam int PAYLOAD_BYTES = 20;
	localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
	localparam int GROUPS        = 4;
	localparam int GROUP_BYTES   = PAYLOAD_BYTES / GROUPS;
	localparam int GROUP_W       = 11;
	localparam int BSUM_W        = 13;
	localparam int WIN_W         = 4;
	localparam int ADDR_W        = 3;

	localparam logic [WIN_W-1:0] WINDOW_RESET  = 4'd6;
	localparam logic [31:0]      ZERO_CHAR_SUM = 32'd960;

	localparam logic RESULT_DELIVER = 1'b0;
	localparam logic RESULT_ACK     = 1'b1;

	localparam logic REG_WINDOW_SIZE = 1'b0;

	typedef logic [SEQ_W-1:0] seq_t;

	typedef struct packed {
		logic cap;
		logic sum1;
		logic sum2;
		logic chk;
		logic wr;
		logic dlv;
		logic ack;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic accepted;
	} status_t;

endpackage

FILE: src/rwr_in_if.sv
// ----------------------------------------------------------------------------
// rwr_in_if: received packet channel
// Valid/ready channel carrying one received packet per request.
// ----------------------------------------------------------------------------
interface rwr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] seq_number;
	logic signed [31:0] ack_field;
	logic signed [31:0] check_value;
	logic [63:0]        payload_bytes_0_7;
	logic [63:0]        payload_bytes_8_15;
	logic [31:0]        payload_bytes_16_19;

	modport source (
		output valid, seq_number, ack_field, check_value,
		output payload_bytes_0_7, payload_bytes_8_15, payload_bytes_16_19,
		input  ready
	);

	modport sink (
		input  valid, seq_number, ack_field, check_value,
		input  payload_bytes_0_7, payload_bytes_8_15, payload_bytes_16_19,
		output ready
	);
endinterface

FILE: src/rwr_out_if.sv
// ----------------------------------------------------------------------------
// rwr_out_if: result channel
// Valid/ready channel carrying delivered payloads and acknowledgements.
// ----------------------------------------------------------------------------
interface rwr_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [63:0]        out_bytes_0_7;
	logic [63:0]        out_bytes_8_15;
	logic [31:0]        out_bytes_16_19;
	logic               reply_sequence;
	logic [3:0]         reply_ack;
	logic signed [31:0] reply_check;
	logic               last;

	modport source (
		output valid, result_kind, out_bytes_0_7, out_bytes_8_15, out_bytes_16_19,
		output reply_sequence, reply_ack, reply_check, last,
		input  ready
	);

	modport sink (
		input  valid, result_kind, out_bytes_0_7, out_bytes_8_15, out_bytes_16_19,
		input  reply_sequence, reply_ack, reply_check, last,
		output ready
	);
endinterface

FILE: src/rwr_ctrl.sv
// ----------------------------------------------------------------------------
// rwr_ctrl: sequencing state machine
// Steps each packet through checksum, window check, store, in-order delivery
// and acknowledgement, and drives the channel handshakes.
// ----------------------------------------------------------------------------
module rwr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rwr_pkg::status_t status,
	output rwr_pkg::cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SUM1  = 8'b0000_0010,
		ST_SUM2  = 8'b0000_0100,
		ST_CHECK = 8'b0000_1000,
		ST_WRITE = 8'b0001_0000,
		ST_READ  = 8'b0010_0000,
		ST_DLV   = 8'b0100_0000,
		ST_ACK   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_SUM1;
				end
			end
			ST_SUM1: begin
				cmd.sum1 = 1'b1;
				state_d  = ST_SUM2;
			end
			ST_SUM2: begin
				cmd.sum2 = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.chk = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				if (status.more && status.accepted) begin
					cmd.dlv = 1'b1;
					state_d = ST_DLV;
				end else begin
					cmd.ack = 1'b1;
					state_d = ST_ACK;
				end
			end
			ST_DLV: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_READ;
				end
			end
			ST_ACK: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_write_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> (cmd.dlv || cmd.ack))
		else $error("store step not followed by a result load");

endmodule

FILE: src/rwr_dp.sv
// ----------------------------------------------------------------------------
// rwr_dp: receiver datapath
// Captures a packet, sums its checksum in a group step and a total step, checks the window,
// holds out-of-order payloads and loads the result register.
// ----------------------------------------------------------------------------
module rwr_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rwr_pkg::cmd_t              cmd,
	output rwr_pkg::status_t           status,
	input  logic [rwr_pkg::WIN_W-1:0]  window_size,
	input  logic signed [31:0]         seq_number,
	input  logic signed [31:0]         ack_field,
	input  logic signed [31:0]         check_value,
	input  logic [63:0]                payload_bytes_0_7,
	input  logic [63:0]                payload_bytes_8_15,
	input  logic [31:0]                payload_bytes_16_19,
	output logic                       result_kind,
	output logic [63:0]                out_bytes_0_7,
	output logic [63:0]                out_bytes_8_15,
	output logic [31:0]                out_bytes_16_19,
	output logic                       reply_sequence,
	output logic [3:0]                 reply_ack,
	output logic signed [31:0]         reply_check,
	output logic                       last
);

	localparam int SEQ_W = rwr_pkg::SEQ_W;
	localparam int PW    = rwr_pkg::PAYLOAD_W;
	localparam int GW    = rwr_pkg::GROUP_W;
	localparam int BW    = rwr_pkg::BSUM_W;
	localparam int GB    = rwr_pkg::GROUP_BYTES;

	localparam rwr_pkg::seq_t SEQ_LAST  = SEQ_W'(rwr_pkg::SEQ_SPACE - 1);
	localparam rwr_pkg::seq_t SEQ_COUNT = SEQ_W'(rwr_pkg::SEQ_SPACE);
	localparam logic [rwr_pkg::WIN_W-1:0] WIN_MAX =
		rwr_pkg::WIN_W'(rwr_pkg::SEQ_SPACE - 1);

	// Sum of a group of bytes, each read as a signed value.
	function automatic logic signed [GW-1:0] group_sum(input logic [8*GB-1:0] bytes);
		logic signed [GW-1:0] acc;
		acc = '0;
		for (int i = 0; i < GB; i++) begin
			acc = acc + {{(GW-8){bytes[8*i+7]}}, bytes[8*i +: 8]};
		end
		return acc;
	endfunction

	// Captured packet
	logic signed [31:0]   seq_q;
	logic signed [31:0]   ack_q;
	logic signed [31:0]   chk_q;
	logic [PW-1:0]        pay_q;

	logic signed [GW-1:0] grp_q [rwr_pkg::GROUPS];
	logic signed [BW-1:0] bsum_q;

	// Control state
	logic                 acc_q;
	rwr_pkg::seq_t        ack_num_q;
	rwr_pkg::seq_t        exp_q;
	rwr_pkg::seq_t        dcnt_q;
	logic                 reply_toggle_q;
	logic [rwr_pkg::SEQ_SPACE-1:0] held_flags_q;

	// Held payload store
	logic [PW-1:0]        held_q [rwr_pkg::SEQ_SPACE];

	// Result register
	logic                 kind_q;
	logic [PW-1:0]        out_pay_q;
	logic                 rseq_q;
	rwr_pkg::seq_t        rack_q;
	logic [31:0]          rchk_q;
	logic                 last_q;

	// Window check
	logic signed [31:0]   total;
	rwr_pkg::seq_t        seq_lo;
	rwr_pkg::seq_t        offset;
	logic [rwr_pkg::WIN_W-1:0] win;
	logic                 in_space;
	logic                 accept;
	rwr_pkg::seq_t        exp_prev;

	always_comb begin
		total    = seq_q + ack_q + {{(32-BW){bsum_q[BW-1]}}, bsum_q};
		seq_lo   = seq_q[SEQ_W-1:0];
		in_space = (seq_q[31:SEQ_W] == '0) && (seq_lo < SEQ_COUNT);
		if (seq_lo >= exp_q) begin
			offset = seq_lo - exp_q;
		end else begin
			offset = seq_lo + SEQ_COUNT - exp_q;
		end
		win      = (window_size > WIN_MAX) ? WIN_MAX : window_size;
		accept   = (total == chk_q) && in_space && (offset < win);
		exp_prev = (exp_q == '0) ? SEQ_LAST : exp_q - SEQ_W'(1);
	end

	// Packet capture and checksum pipeline
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			seq_q <= seq_number;
			ack_q <= ack_field;
			chk_q <= check_value;
			pay_q <= {payload_bytes_16_19, payload_bytes_8_15, payload_bytes_0_7};
		end
		if (cmd.sum1) begin
			for (int g = 0; g < rwr_pkg::GROUPS; g++) begin
				grp_q[g] <= group_sum(pay_q[8*GB*g +: 8*GB]);
			end
		end
		if (cmd.sum2) begin
			bsum_q <= {{(BW-GW){grp_q[0][GW-1]}}, grp_q[0]}
			        + {{(BW-GW){grp_q[1][GW-1]}}, grp_q[1]}
			        + {{(BW-GW){grp_q[2][GW-1]}}, grp_q[2]}
			        + {{(BW-GW){grp_q[3][GW-1]}}, grp_q[3]};
		end
		if (cmd.chk) begin
			ack_num_q <= accept ? seq_lo : exp_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= 1'b0;
			exp_q          <= '0;
			dcnt_q         <= '0;
			reply_toggle_q <= 1'b1;
			held_flags_q   <= '0;
		end else begin
			if (cmd.chk) begin
				acc_q <= accept;
			end
			if (cmd.wr) begin
				dcnt_q <= '0;
				if (acc_q) begin
					held_flags_q[seq_q[SEQ_W-1:0]] <= 1'b1;
				end
			end
			if (cmd.dlv) begin
				held_flags_q[exp_q] <= 1'b0;
				exp_q  <= (exp_q == SEQ_LAST) ? '0 : exp_q + SEQ_W'(1);
				dcnt_q <= dcnt_q + SEQ_W'(1);
			end
			if (cmd.ack) begin
				reply_toggle_q <= ~reply_toggle_q;
			end
		end
	end

	// Store write, and registered read or acknowledgement load into the result register
	always_ff @(posedge clk) begin
		if (cmd.wr && acc_q) begin
			held_q[seq_q[SEQ_W-1:0]] <= pay_q;
		end
		if (cmd.dlv) begin
			kind_q    <= rwr_pkg::RESULT_DELIVER;
			out_pay_q <= held_q[exp_q];
			rseq_q    <= 1'b0;
			rack_q    <= '0;
			rchk_q    <= '0;
			last_q    <= 1'b0;
		end
		if (cmd.ack) begin
			kind_q    <= rwr_pkg::RESULT_ACK;
			out_pay_q <= '0;
			rseq_q    <= reply_toggle_q;
			rack_q    <= ack_num_q;
			rchk_q    <= {31'd0, reply_toggle_q} + {{(32-SEQ_W){1'b0}}, ack_num_q}
			           + rwr_pkg::ZERO_CHAR_SUM;
			last_q    <= 1'b1;
		end
	end

	assign status.accepted = acc_q;
	assign status.more     = held_flags_q[exp_q] && (dcnt_q < SEQ_LAST);

	assign result_kind     = kind_q;
	assign out_bytes_0_7   = out_pay_q[63:0];
	assign out_bytes_8_15  = out_pay_q[127:64];
	assign out_bytes_16_19 = out_pay_q[159:128];
	assign reply_sequence  = rseq_q;
	assign reply_ack       = 4'(rack_q);
	assign reply_check     = rchk_q;
	assign last            = last_q;

	a_expected_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q < SEQ_COUNT)
		else $error("expected sequence left the sequence space");

	a_toggle_flips: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ack |=> reply_toggle_q != $past(reply_toggle_q))
		else $error("reply bit did not alternate");

	a_flags_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(held_flags_q) < rwr_pkg::SEQ_SPACE)
		else $error("every sequence number marked held");

endmodule

FILE: src/reordering_window_receiver.sv
// ----------------------------------------------------------------------------
// reordering_window_receiver: selective-repeat receiver with reorder buffer
// Checks each received packet, holds in-window packets, releases them in
// sequence order and answers every packet with one acknowledgement.
// ----------------------------------------------------------------------------
// A new request is taken only once the acknowledgement of the last one has
// been taken; released payloads are read one at a time through the single
// read port of the held payload store.
// Reset (arst_n, asynchronous): expected number 0, reply bit 1, all held
// marks clear, window size 6. The held store itself needs no clearing pass.
module reordering_window_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	rwr_in_if.sink                        pkt_in,
	rwr_out_if.source                     res_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rwr_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Configuration register: the receive window width. A value above the
	// largest usable width is clamped in the datapath, so it is stored as is.
	logic [rwr_pkg::WIN_W-1:0] window_size_q;
	logic                      reg_index;
	logic                      write_en;

	assign pready    = 1'b1;
	assign reg_index = paddr[rwr_pkg::ADDR_W-1];
	assign write_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= rwr_pkg::WINDOW_RESET;
		end else if (write_en && (reg_index == rwr_pkg::REG_WINDOW_SIZE)) begin
			window_size_q <= pwdata[rwr_pkg::WIN_W-1:0];
		end
	end

	// Reads return the register; addresses past it read as zero.
	always_comb begin
		unique case (reg_index)
			rwr_pkg::REG_WINDOW_SIZE: begin
				prdata = {{(32-rwr_pkg::WIN_W){1'b0}}, window_size_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// The controller and datapath talk only through these two groups.
	rwr_pkg::cmd_t    cmd;
	rwr_pkg::status_t status;

	// The controller owns both handshakes: a packet is taken only when the
	// machine is idle, and the result register is shown as valid only in the
	// delivery and acknowledgement states, where it waits for the consumer.
	rwr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pkt_in.valid),
		.in_ready  (pkt_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath captures the packet, forms the checksum in two steps,
	// decides acceptance against the window, keeps held payloads and loads
	// one result at a time into the output register.
	rwr_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.window_size         (window_size_q),
		.seq_number          (pkt_in.seq_number),
		.ack_field           (pkt_in.ack_field),
		.check_value         (pkt_in.check_value),
		.payload_bytes_0_7   (pkt_in.payload_bytes_0_7),
		.payload_bytes_8_15  (pkt_in.payload_bytes_8_15),
		.payload_bytes_16_19 (pkt_in.payload_bytes_16_19),
		.result_kind         (res_out.result_kind),
		.out_bytes_0_7       (res_out.out_bytes_0_7),
		.out_bytes_8_15      (res_out.out_bytes_8_15),
		.out_bytes_16_19     (res_out.out_bytes_16_19),
		.reply_sequence      (res_out.reply_sequence),
		.reply_ack           (res_out.reply_ack),
		.reply_check         (res_out.reply_check),
		.last                (res_out.last)
	);

endmodule
